FILE: rtl/core/sss_pkg.sv
package sss_pkg;

  // Field widths of one command beat and one result beat.
  localparam int CMD_W   = 4;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int LINE_W  = 16;
  localparam int DEPTH_W = 8;
  localparam int IDX_W   = 6;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_VAR   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TMP   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_POP_DEPTH = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_READ_TMP  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_UPD_TMP   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_TEST_MARK = 4'd8;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

  // Entry count operations.
  localparam logic [2:0] CNT_HOLD = 3'd0;
  localparam logic [2:0] CNT_INC  = 3'd1;
  localparam logic [2:0] CNT_DEC  = 3'd2;
  localparam logic [2:0] CNT_ZERO = 3'd3;
  localparam logic [2:0] CNT_CHK  = 3'd4;

  // Table write operations.
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_VAR  = 2'd1;
  localparam logic [1:0] WR_TMP  = 2'd2;
  localparam logic [1:0] WR_UPD  = 2'd3;

  // Result forms.
  localparam logic [2:0] RES_NONE  = 3'd0;
  localparam logic [2:0] RES_FULL  = 3'd1;
  localparam logic [2:0] RES_DUP   = 3'd2;
  localparam logic [2:0] RES_MISS  = 3'd3;
  localparam logic [2:0] RES_FOUND = 3'd4;
  localparam logic [2:0] RES_TOP   = 3'd5;
  localparam logic [2:0] RES_ENTRY = 3'd6;
  localparam logic [2:0] RES_BAD   = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic       scan_step;
    logic       rd_scan;
    logic [2:0] cnt_op;
    logic [1:0] wr_op;
    logic       res_load;
    logic [2:0] res_code;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             idx_bad;
    logic             hit;
    logic             scan_end;
    logic             out_free;
  } sts_t;

endpackage

FILE: rtl/core/sss_if.sv
// Command channel.
interface sss_in_if import sss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [KEY_W-1:0]          name_key;
  logic signed [VAL_W-1:0]   value;
  logic [LINE_W-1:0]         line_no;
  logic [DEPTH_W-1:0]        scope_depth;
  logic [IDX_W-1:0]          entry_index;

  modport source (output valid, cmd, name_key, value, line_no, scope_depth, entry_index,
                  input ready);
  modport sink (input valid, cmd, name_key, value, line_no, scope_depth, entry_index,
                output ready);
endinterface

// Result channel.
interface sss_out_if import sss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic [IDX_W-1:0]          result_index;
  logic                      index_valid;
  logic signed [VAL_W-1:0]   tmp_value;
  logic                      is_temporary;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, status, result_index, index_valid, tmp_value,
                  is_temporary, entry_count, input ready);
  modport sink (input valid, status, result_index, index_valid, tmp_value,
                is_temporary, entry_count, output ready);
endinterface

FILE: rtl/core/sss_dpath.sv
module sss_dpath import sss_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_t                    ctl,
  output sts_t                    sts,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [KEY_W-1:0]        in_name_key,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [LINE_W-1:0]       in_line_no,
  input  logic [DEPTH_W-1:0]      in_scope_depth,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic [IDX_W-1:0]        out_result_index,
  output logic                    out_index_valid,
  output logic signed [VAL_W-1:0] out_tmp_value,
  output logic                    out_is_temporary,
  output logic [COUNT_W-1:0]      out_entry_count
);

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = CNT_W + IDX_W;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    logic [LINE_W-1:0]   line;
    logic [DEPTH_W-1:0]  depth;
    logic                kind;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;
  entry_t wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   value_r;
  logic [LINE_W-1:0]  line_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [IDX_W-1:0]   idx_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt, ptr_m1;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    chk_r, chk_nxt;
  logic             match;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic [IDX_W-1:0]        rindex_r, rindex_nxt;
  logic                    ivalid_r, ivalid_nxt;
  logic [VAL_W-1:0]        tval_r, tval_nxt;
  logic                    istmp_r, istmp_nxt;
  logic [COUNT_W-1:0]      cnt_out_r;

  // Capture the accepted command beat.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_name_key;
      value_r <= in_value;
      line_r  <= in_line_no;
      depth_r <= in_scope_depth;
      idx_r   <= in_entry_index;
    end
  end

  // Symbol table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign ptr_m1  = ptr_r - 1'b1;
  assign rd_addr = ctl.rd_scan ? AW'(ptr_m1) : AW'(idx_r);

  // Write data for the three ways an entry is written.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = AW'(count_r);
    wr_data = rd_data_r;
    unique case (ctl.wr_op)
      WR_VAR: begin
        wr_data = '{key: key_r[KEY_BITS-1:0], value: '0, line: line_r,
                    depth: depth_r, kind: 1'b0};
      end
      WR_TMP: begin
        wr_data = '{key: '0, value: value_r, line: line_r,
                    depth: depth_r, kind: 1'b1};
      end
      WR_UPD: begin
        wr_addr       = AW'(idx_r);
        wr_data.value = value_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    unique case (ctl.cnt_op)
      CNT_INC:  count_nxt = count_r + 1'b1;
      CNT_DEC:  count_nxt = (count_r != '0) ? count_r - 1'b1 : count_r;
      CNT_ZERO: count_nxt = '0;
      CNT_CHK:  count_nxt = CNT_W'(chk_r) + 1'b1;
      default:  count_nxt = count_r;
    endcase
  end

  // Top-down walk: one read issued per cycle, the previous read checked.
  always_comb begin
    ptr_nxt  = ptr_r;
    pend_nxt = pend_r;
    chk_nxt  = chk_r;
    if (ctl.scan_init) begin
      ptr_nxt  = count_r;
      pend_nxt = 1'b0;
    end else if (ctl.scan_step) begin
      ptr_nxt  = ptr_m1;
      pend_nxt = 1'b1;
      chk_nxt  = AW'(ptr_m1);
    end
  end

  // Pop depth stops below the threshold; search and insert of a variable stop on a matching variable.
  assign match = (cmd_r == CMD_POP_DEPTH) ? (rd_data_r.depth < depth_r)
                                          : (!rd_data_r.kind &&
                                             rd_data_r.key == key_r[KEY_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    chk_r <= chk_nxt;
  end

  // Status toward the controller.
  always_comb begin
    sts.cmd      = cmd_r;
    sts.full     = (count_r == CNT_W'(TABLE_ENTRIES));
    sts.idx_bad  = (CMP_W'(idx_r) >= CMP_W'(count_r));
    sts.hit      = pend_r && match;
    sts.scan_end = (ptr_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  // Result beat assembly.
  always_comb begin
    status_nxt = ST_OK;
    rindex_nxt = '0;
    ivalid_nxt = 1'b0;
    tval_nxt   = '0;
    istmp_nxt  = 1'b0;
    unique case (ctl.res_code)
      RES_FULL: status_nxt = ST_FULL;
      RES_DUP: begin
        status_nxt = ST_DUPLICATE;
        rindex_nxt = IDX_W'(chk_r);
        ivalid_nxt = 1'b1;
      end
      RES_MISS: status_nxt = ST_NOT_FOUND;
      RES_FOUND: begin
        rindex_nxt = IDX_W'(chk_r);
        ivalid_nxt = 1'b1;
      end
      RES_TOP: begin
        if (count_r != '0) begin
          rindex_nxt = IDX_W'(count_r - 1'b1);
          ivalid_nxt = 1'b1;
        end
        istmp_nxt = (cmd_r == CMD_INS_TMP);
      end
      RES_ENTRY: begin
        rindex_nxt = idx_r;
        ivalid_nxt = 1'b1;
        tval_nxt   = (cmd_r == CMD_READ_TMP) ? rd_data_r.value : '0;
        istmp_nxt  = rd_data_r.kind;
      end
      RES_BAD: status_nxt = ST_BAD_INDEX;
      default: status_nxt = ST_OK;
    endcase
  end

  // Output register: holds a beat until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The entry count is captured with the beat, since a later command may
  // change the live count while this beat still waits.
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      status_r  <= status_nxt;
      rindex_r  <= rindex_nxt;
      ivalid_r  <= ivalid_nxt;
      tval_r    <= tval_nxt;
      istmp_r   <= istmp_nxt;
      cnt_out_r <= COUNT_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_index = rindex_r;
  assign out_index_valid  = ivalid_r;
  assign out_tmp_value    = tval_r;
  assign out_is_temporary = istmp_r;
  assign out_entry_count  = cnt_out_r;

endmodule

FILE: rtl/core/sss_ctrl.sv
module sss_ctrl import sss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    ctl           = '0;
    ctl.cnt_op    = CNT_HOLD;
    ctl.wr_op     = WR_NONE;
    ctl.res_code  = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (sts.cmd)
          CMD_INS_VAR: begin
            if (sts.full) begin
              res_nxt = RES_FULL;
            end else begin
              ctl.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          CMD_INS_TMP: begin
            if (sts.full) begin
              res_nxt = RES_FULL;
            end else begin
              ctl.wr_op  = WR_TMP;
              ctl.cnt_op = CNT_INC;
              res_nxt    = RES_TOP;
            end
          end
          CMD_SEARCH, CMD_POP_DEPTH: begin
            ctl.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          CMD_POP: begin
            ctl.cnt_op = CNT_DEC;
            res_nxt    = RES_TOP;
          end
          CMD_CLEAR: begin
            ctl.cnt_op = CNT_ZERO;
            res_nxt    = RES_NONE;
          end
          CMD_READ_TMP, CMD_UPD_TMP, CMD_TEST_MARK: begin
            if (sts.idx_bad) begin
              res_nxt = RES_BAD;
            end else begin
              state_nxt = S_READ;
            end
          end
          default: res_nxt = RES_NONE;
        endcase
      end
      S_SCAN: begin
        ctl.rd_scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_FINISH;
          if (sts.cmd == CMD_POP_DEPTH) begin
            ctl.cnt_op = CNT_CHK;
            res_nxt    = RES_TOP;
          end else if (sts.cmd == CMD_INS_VAR) begin
            res_nxt = RES_DUP;
          end else begin
            res_nxt = RES_FOUND;
          end
        end else if (sts.scan_end) begin
          state_nxt = S_FINISH;
          if (sts.cmd == CMD_POP_DEPTH) begin
            ctl.cnt_op = CNT_ZERO;
            res_nxt    = RES_TOP;
          end else if (sts.cmd == CMD_INS_VAR) begin
            ctl.wr_op  = WR_VAR;
            ctl.cnt_op = CNT_INC;
            res_nxt    = RES_TOP;
          end else begin
            res_nxt = RES_MISS;
          end
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_READ: begin
        if (sts.cmd == CMD_UPD_TMP) begin
          ctl.wr_op = WR_UPD;
        end
        res_nxt   = RES_ENTRY;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_NONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/scoped_symbol_stack_core.sv
// Scoped symbol stack: a stack of compiler symbols with scope depths.
// Commands arrive on in_bus, one beat per command, and each command gives
// exactly one result beat on out_bus, in order. Both channels move a beat at
// a clock edge where valid and ready are both high.
// One command is worked on at a time. Search, insert of a variable and pop
// by depth walk the table from the top down through the single read port of
// the table memory, one entry per cycle. Read, update and test of an entry
// with a valid index pass through a read state; other commands go from
// dispatch straight to the finish state. in_bus.ready is high only while
// the controller is idle, which it is again once a result is registered.
// The result sits in an output register; a new command is accepted while it
// waits, but its result is held back until the receiver has taken the old
// one, so a stalled receiver stalls the block after at most one command.
// Synchronous reset empties the stack (entry count zero) and drops any
// pending result; the table memory itself is not cleared and needs no
// clearing pass.
module scoped_symbol_stack_core import sss_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64
) (
  input logic     clk,
  input logic     rst_n,
  sss_in_if.sink    in_bus,
  sss_out_if.source out_bus
);

  ctl_t ctl;
  sts_t sts;

  // Sequencer.
  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Table, count, walk pointer and result register.
  sss_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_bus.cmd),
    .in_name_key      (in_bus.name_key),
    .in_value         (in_bus.value),
    .in_line_no       (in_bus.line_no),
    .in_scope_depth   (in_bus.scope_depth),
    .in_entry_index   (in_bus.entry_index),
    .out_ready        (out_bus.ready),
    .out_valid        (out_bus.valid),
    .out_status       (out_bus.status),
    .out_result_index (out_bus.result_index),
    .out_index_valid  (out_bus.index_valid),
    .out_tmp_value    (out_bus.tmp_value),
    .out_is_temporary (out_bus.is_temporary),
    .out_entry_count  (out_bus.entry_count)
  );

endmodule

FILE: tb/sv/scoped_symbol_stack_core_test.sv
module scoped_symbol_stack_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  localparam int SYMBOLS       = 64;
  localparam int POOL_KEYS     = 16;
  localparam int RANDOM_ITEMS  = 600;
  localparam int TAIL_ITEMS    = 40;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 400000;

  // Command codes that the block answers without doing anything.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0]        op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [LINE_W-1:0]       line;
    logic [DEPTH_W-1:0]      depth;
    logic [IDX_W-1:0]        index;
    logic                    hold;
  } sym_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        index;
    logic                    index_valid;
    logic signed [VAL_W-1:0] tmp;
    logic                    is_tmp;
    logic [COUNT_W-1:0]      count;
  } sym_result_t;

  logic clk;
  logic rst_n;

  sss_in_if  in_ch();
  sss_out_if out_ch();

  scoped_symbol_stack_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // Expected contents of the symbol table.
  logic [KEY_W-1:0]        tab_key    [SYMBOLS];
  logic signed [VAL_W-1:0] tab_value  [SYMBOLS];
  logic [LINE_W-1:0]       tab_line   [SYMBOLS];
  logic [DEPTH_W-1:0]      tab_depth  [SYMBOLS];
  logic                    tab_is_tmp [SYMBOLS];
  int                      tab_count = 0;

  sym_cmd_t    queued_cmds[$];
  sym_result_t due_results[$];
  sym_cmd_t    cur_cmd;

  int gap_left     = 0;
  int quiet_left   = 0;
  int stall_left   = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int gen_count    = 0;

  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  // Index of the topmost variable with this key, or -1.
  function automatic int topmost_var(logic [KEY_W-1:0] key);
    for (int i = tab_count - 1; i >= 0; i--) begin
      if (!tab_is_tmp[i] && tab_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void push_symbol(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                      logic [LINE_W-1:0] line, logic [DEPTH_W-1:0] depth,
                                      logic is_tmp);
    tab_key[tab_count]    = key;
    tab_value[tab_count]  = value;
    tab_line[tab_count]   = line;
    tab_depth[tab_count]  = depth;
    tab_is_tmp[tab_count] = is_tmp;
    tab_count++;
  endfunction

  // Applies one command to the expected table and returns its result beat.
  function automatic sym_result_t table_step(sym_cmd_t c);
    sym_result_t r;
    int hit;
    r = '0;
    case (c.op)
      CMD_INS_VAR: begin
        if (tab_count >= SYMBOLS) begin
          r.status = ST_FULL;
        end else begin
          hit = topmost_var(c.key);
          if (hit >= 0) begin
            r.status = ST_DUPLICATE;
            r.index = IDX_W'(hit);
            r.index_valid = 1'b1;
          end else begin
            r.index = IDX_W'(tab_count);
            r.index_valid = 1'b1;
            push_symbol(c.key, '0, c.line, c.depth, 1'b0);
          end
        end
      end
      CMD_INS_TMP: begin
        if (tab_count >= SYMBOLS) begin
          r.status = ST_FULL;
        end else begin
          // A temporary keeps no name, so it can never match a search.
          r.index = IDX_W'(tab_count);
          r.index_valid = 1'b1;
          r.is_tmp = 1'b1;
          push_symbol('0, c.value, c.line, c.depth, 1'b1);
        end
      end
      CMD_SEARCH: begin
        hit = topmost_var(c.key);
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.index = IDX_W'(hit);
          r.index_valid = 1'b1;
        end
      end
      CMD_POP, CMD_POP_DEPTH: begin
        if (c.op == CMD_POP) begin
          if (tab_count > 0) tab_count--;
        end else begin
          while (tab_count > 0 && tab_depth[tab_count - 1] >= c.depth) tab_count--;
        end
        if (tab_count > 0) begin
          r.index = IDX_W'(tab_count - 1);
          r.index_valid = 1'b1;
        end
      end
      CMD_CLEAR: begin
        tab_count = 0;
      end
      CMD_READ_TMP, CMD_UPD_TMP, CMD_TEST_MARK: begin
        if (c.index >= tab_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.index = c.index;
          r.index_valid = 1'b1;
          if (c.op == CMD_READ_TMP) r.tmp = tab_value[c.index];
          else if (c.op == CMD_UPD_TMP) tab_value[c.index] = c.value;
          r.is_tmp = tab_is_tmp[c.index];
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(tab_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly a key from the small pool so that duplicates and hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return rand_key();
    return key_pool[$urandom_range(0, POOL_KEYS - 1)];
  endfunction

  // Mostly an index near the live entries, including one just past the top.
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, SYMBOLS - 1));
    return IDX_W'($urandom_range(0, (gen_count < SYMBOLS - 1) ? gen_count : SYMBOLS - 1));
  endfunction

  // Queues one command and keeps a rough count of entries to steer indexes.
  task automatic add_cmd(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                         logic [VAL_W-1:0] value, logic [LINE_W-1:0] line,
                         logic [DEPTH_W-1:0] depth, logic [IDX_W-1:0] index,
                         logic hold);
    sym_cmd_t c;
    c = '{op: op, key: key, value: value, line: line, depth: depth, index: index,
          hold: hold};
    queued_cmds.push_back(c);
    case (op)
      CMD_INS_VAR, CMD_INS_TMP: if (gen_count < SYMBOLS) gen_count++;
      CMD_POP: if (gen_count > 0) gen_count--;
      CMD_POP_DEPTH: gen_count = gen_count / 2;
      CMD_CLEAR: gen_count = 0;
      default: begin
      end
    endcase
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d: %s expected %0h, got %0h", results_seen, field, want, got);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Command driver: presents queued commands and predicts each accepted beat.
  always @(posedge clk) begin : drive_proc
    logic fire;
    logic go;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) due_results.push_back(table_step(cur_cmd));
      if (fire || !in_ch.valid) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_cmds.size() > 0 &&
                     !(queued_cmds[0].hold && due_results.size() > 0)) begin
          go = 1'b1;
          cur_cmd = queued_cmds.pop_front();
          // Gaps come in bursts, with quiet stretches and none near the end.
          if (quiet_left > 0) begin
            quiet_left--;
          end else if (queued_cmds.size() >= TAIL_ITEMS) begin
            if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(20, 60);
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 18);
          end
        end
        in_ch.valid <= go;
        if (go) begin
          in_ch.cmd         <= cur_cmd.op;
          in_ch.name_key    <= cur_cmd.key;
          in_ch.value       <= cur_cmd.value;
          in_ch.line_no     <= cur_cmd.line;
          in_ch.scope_depth <= cur_cmd.depth;
          in_ch.entry_index <= cur_cmd.index;
        end
      end
    end
  end

  // Result monitor: checks every result beat against the oldest expectation.
  always @(posedge clk) begin : observe_proc
    sym_result_t want;
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d arrived with no command outstanding", results_seen);
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("result_index", 32'(want.index), 32'(out_ch.result_index));
          check_field("index_valid", 32'(want.index_valid), 32'(out_ch.index_valid));
          check_field("tmp_value", want.tmp, out_ch.tmp_value);
          check_field("is_temporary", 32'(want.is_tmp), 32'(out_ch.is_temporary));
          check_field("entry_count", 32'(want.count), 32'(out_ch.entry_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (quiet_left == 0 && queued_cmds.size() >= TAIL_ITEMS &&
            $urandom_range(0, 5) == 0) begin
          rdy = 1'b0;
          stall_left = $urandom_range(0, 17);
        end
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin : main_proc
    int base;
    int scope_base;
    int lvl;
    int fills;
    int roll;
    int n;
    logic [DEPTH_W-1:0] d;
    logic [KEY_W-1:0] deep_key;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = '0;
    in_ch.name_key    = '0;
    in_ch.value       = '0;
    in_ch.line_no     = '0;
    in_ch.scope_depth = '0;
    in_ch.entry_index = '0;
    out_ch.ready      = 1'b0;

    foreach (key_pool[i]) key_pool[i] = rand_key();

    // Directed part: empty table, extremes, duplicates, marks and unused codes.
    add_cmd(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_POP_DEPTH, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_SEARCH, '1, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_READ_TMP, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_INS_VAR, '1, '1, '1, '1, '1, 1'b0);
    add_cmd(CMD_INS_VAR, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_INS_TMP, '0, 32'h8000_0000, 16'h1234, 8'd1, '0, 1'b0);
    add_cmd(CMD_INS_TMP, '1, 32'h7fff_ffff, '1, '1, '1, 1'b0);
    add_cmd(CMD_INS_VAR, '1, '0, 16'h0042, 8'd3, '0, 1'b0);
    add_cmd(CMD_INS_VAR, '0, '0, 16'h0043, 8'd3, '0, 1'b0);
    add_cmd(CMD_SEARCH, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_READ_TMP, '0, '0, '0, '0, 6'd2, 1'b0);
    add_cmd(CMD_UPD_TMP, '0, '0, '0, '0, 6'd3, 1'b0);
    add_cmd(CMD_READ_TMP, '0, '0, '0, '0, 6'd3, 1'b0);
    // A variable's value is overwritten too and reads back.
    add_cmd(CMD_UPD_TMP, '0, 32'h1234_5678, '0, '0, 6'd0, 1'b0);
    add_cmd(CMD_READ_TMP, '0, '0, '0, '0, 6'd0, 1'b0);
    add_cmd(CMD_TEST_MARK, '0, '0, '0, '0, 6'd1, 1'b0);
    add_cmd(CMD_TEST_MARK, '0, '0, '0, '0, '1, 1'b0);
    add_cmd(CMD_POP_DEPTH, '0, '0, '0, 8'd200, '0, 1'b0);
    add_cmd(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    // A temporary's stored zero key must not satisfy a search for key zero.
    add_cmd(CMD_INS_TMP, '0, 32'h0000_0005, '0, 8'd2, '0, 1'b0);
    add_cmd(CMD_SEARCH, '0, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_UNUSED_LO, '1, '1, '1, '1, '1, 1'b0);
    add_cmd(CMD_UNUSED_HI, '1, '1, '1, '1, '1, 1'b0);
    add_cmd(CMD_CLEAR, '0, '0, '0, '0, '0, 1'b0);

    // Random part: mostly nested scopes with inserts, lookups and scope exits.
    base = queued_cmds.size();
    lvl = 0;
    fills = 0;
    // The first random command waits for the directed results to drain.
    add_cmd(CMD_TEST_MARK, '0, '0, '0, '0, '0, 1'b1);
    while (queued_cmds.size() - base < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if ((fills == 0 && queued_cmds.size() - base > RANDOM_ITEMS / 2) || roll >= 97) begin
        // Fill the table to the brim, overflow it, then walk it end to end.
        fills++;
        add_cmd(CMD_CLEAR, '0, '0, '0, '0, '0, 1'b1);
        deep_key = rand_key();
        for (int i = 0; i < SYMBOLS + 2; i++) begin
          if (i % 4 == 3)
            add_cmd(CMD_INS_TMP, rand_key(), $urandom, LINE_W'($urandom),
                    DEPTH_W'(i / 8), '0, 1'b0);
          else
            add_cmd(CMD_INS_VAR, (i == 0) ? deep_key : rand_key(), $urandom,
                    LINE_W'($urandom), DEPTH_W'(i / 8), '0, 1'b0);
        end
        add_cmd(CMD_INS_VAR, deep_key, '0, '0, '0, '0, 1'b0);
        add_cmd(CMD_SEARCH, deep_key, '0, '0, '0, '0, 1'b0);
        add_cmd(CMD_SEARCH, rand_key(), '0, '0, '0, '0, 1'b0);
        add_cmd(CMD_TEST_MARK, '0, '0, '0, '0, IDX_W'(SYMBOLS - 1), 1'b0);
        add_cmd(CMD_POP_DEPTH, '0, '0, '0, 8'd4, '0, 1'b0);
        add_cmd(CMD_POP_DEPTH, '0, '0, '0, '0, '0, 1'b0);
        gen_count = 0;
        lvl = 0;
      end else if (roll < 68) begin
        scope_base = gen_count;
        if (lvl < 8) lvl++;
        d = ($urandom_range(0, 5) == 0) ? DEPTH_W'($urandom_range(0, 255)) : DEPTH_W'(lvl);
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0)
            add_cmd(CMD_INS_TMP, rand_key(), $urandom, LINE_W'($urandom), d,
                    pick_index(), 1'b0);
          else
            add_cmd(CMD_INS_VAR, pick_key(), $urandom, LINE_W'($urandom), d,
                    pick_index(), 1'b0);
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: add_cmd(CMD_SEARCH, pick_key(), $urandom, LINE_W'($urandom), d,
                       pick_index(), 1'b0);
            1: add_cmd(CMD_READ_TMP, rand_key(), $urandom, LINE_W'($urandom), d,
                       pick_index(), 1'b0);
            2: add_cmd(CMD_UPD_TMP, rand_key(), $urandom, LINE_W'($urandom), d,
                       pick_index(), 1'b0);
            default:
              add_cmd(CMD_TEST_MARK, rand_key(), $urandom, LINE_W'($urandom), d,
                      pick_index(), 1'b0);
          endcase
        end
        // Leave the scope about half the time.
        if ($urandom_range(0, 1) == 0) begin
          add_cmd(CMD_POP_DEPTH, rand_key(), $urandom, LINE_W'($urandom), d,
                  pick_index(), 1'b0);
          gen_count = scope_base;
          lvl--;
        end
      end else if (roll < 78) begin
        if ($urandom_range(0, 1) == 0)
          add_cmd(CMD_POP, rand_key(), $urandom, LINE_W'($urandom), DEPTH_W'($urandom),
                  IDX_W'($urandom), 1'b0);
        else
          add_cmd(CMD_POP_DEPTH, rand_key(), $urandom, LINE_W'($urandom),
                  DEPTH_W'($urandom_range(0, 255)), IDX_W'($urandom), 1'b0);
      end else if (roll < 82) begin
        add_cmd(CMD_CLEAR, rand_key(), $urandom, LINE_W'($urandom), DEPTH_W'($urandom),
                IDX_W'($urandom), 1'b0);
        lvl = 0;
      end else if (roll < 90) begin
        add_cmd(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand_key(),
                $urandom, LINE_W'($urandom), DEPTH_W'($urandom), IDX_W'($urandom), 1'b0);
      end else begin
        add_cmd(CMD_W'($urandom_range(CMD_INS_VAR, CMD_UNUSED_HI)), rand_key(),
                $urandom, LINE_W'($urandom), DEPTH_W'($urandom), IDX_W'($urandom), 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (queued_cmds.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
